/* sv/mtn_pkg.sv */
// Package for the top-magnitude mean block: shared widths, codes and the
// controller state, command and status types. No dependencies.
package mtn_pkg;

   localparam int CFG_W     = 5;
   localparam int COUNT_W   = 5;
   localparam int MEAN_W    = 24;
   localparam int FRAC_BITS = 8;

   localparam logic [CFG_W-1:0]   CFG_RESET = 5'd1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV,
      ST_OUT
   } mtn_state_type;

   typedef struct packed {
      logic in_ready;
      logic insert;
      logic start;
      logic sum_step;
      logic div_step;
      logic load_out;
   } mtn_cmd_type;

   typedef struct packed {
      logic k_valid;
      logic sum_last;
      logic div_done;
      logic out_free;
   } mtn_stat_type;

endpackage

/* sv/mtn_if.sv */
// Channel interfaces for the top-magnitude mean block: sample requests and
// mean responses. Depends on mtn_pkg.
interface mtn_req_if #(
   parameter int SAMPLE_BITS = 16
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

interface mtn_rsp_if ();
   logic                       valid;
   logic                       ready;
   logic [mtn_pkg::MEAN_W-1:0] mean_scaled;
   logic                       ok;

   modport source (output valid, output mean_scaled, output ok, input ready);
   modport sink   (input valid, input mean_scaled, input ok, output ready);
endinterface

/* sv/mean_of_top_n_abs_values.sv */
// Top level: mean of the K largest sample magnitudes of a series, times 256.
// Samples not marked last are taken at one per cycle. A last sample's response is registered
// once the sum over the K cells and the one-bit-per-cycle divide are done (neither runs when ok
// is 0) and the output register is free; no sample is taken before that response is loaded.
// Reset is synchronous and active high: cells and count clear, maxima_count returns to 1.
// Depends on mtn_pkg, mtn_if, mtn_ctrl and mtn_datapath.
module mean_of_top_n_abs_values #(
   parameter int MAX_TOP     = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   mtn_req_if.sink                  req_ch,
   mtn_rsp_if.source                rsp_ch,
   input  logic                     csr_write_enable,
   input  logic [mtn_pkg::CFG_W-1:0] csr_write_data
);
   import mtn_pkg::*;

   // The controller and the datapath talk only through these two structs.
   // Request transactions are taken only while the controller is idle; a
   // finished response sits in the datapath's output register, so the next
   // series can start while that transaction still waits for the sink.
   mtn_cmd_type  cmd;
   mtn_stat_type stat;

   mtn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.last),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the sorted cells, the saturating sample count, the
   // accumulator that doubles as the dividend, and the response register.
   mtn_datapath #(
      .MAX_TOP     (MAX_TOP),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .sample           (req_ch.sample),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_mean_scaled  (rsp_ch.mean_scaled),
      .rsp_ok           (rsp_ch.ok)
   );

   assign req_ch.ready = cmd.in_ready;

endmodule

/* sv/mtn_ctrl.sv */
// Controller state machine for the top-magnitude mean block.
// Depends on mtn_pkg for the state, command and status types.
module mtn_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last,
   input  mtn_pkg::mtn_stat_type stat,
   output mtn_pkg::mtn_cmd_type  cmd
);
   import mtn_pkg::*;

   mtn_state_type state_ff;
   mtn_state_type state_in;
   logic          accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_last) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (!stat.k_valid) begin
               state_in = ST_OUT;
            end else if (stat.sum_last) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.in_ready = 1'b1;
            cmd.insert   = accept;
            cmd.start    = accept && req_last;
         end
         ST_SUM: begin
            cmd.sum_step = stat.k_valid;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_OUT: begin
            cmd.load_out = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* sv/mtn_datapath.sv */
// Datapath for the top-magnitude mean block: sorted cell chain, sample count,
// accumulator, restoring divider and output register. Depends on mtn_pkg.
module mtn_datapath #(
   parameter int MAX_TOP     = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mtn_pkg::mtn_cmd_type           cmd,
   output mtn_pkg::mtn_stat_type          stat,
   input  logic signed [SAMPLE_BITS-1:0]  sample,
   input  logic                           csr_write_enable,
   input  logic [mtn_pkg::CFG_W-1:0]      csr_write_data,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [mtn_pkg::MEAN_W-1:0]     rsp_mean_scaled,
   output logic                           rsp_ok
);
   import mtn_pkg::*;

   localparam int IDX_W  = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1;
   localparam int CNT_W  = $clog2(MAX_TOP + 1);
   localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_TOP + 1);
   localparam int DVD_W  = SUM_W + FRAC_BITS;
   localparam int DCNT_W = $clog2(DVD_W);

   logic [SAMPLE_BITS-1:0] cells_ff [MAX_TOP];
   logic [SAMPLE_BITS-1:0] cells_in [MAX_TOP];
   logic [SAMPLE_BITS-1:0] prev_val [MAX_TOP];
   logic [MAX_TOP-1:0]     gt;
   logic [SAMPLE_BITS-1:0] raw;
   logic [SAMPLE_BITS-1:0] mag;

   logic [CFG_W-1:0]   maxima_count_ff;
   logic [COUNT_W-1:0] seen_ff;
   logic [COUNT_W-1:0] seen_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;
   logic [DVD_W-1:0]   quot_ff;
   logic [DVD_W-1:0]   quot_in;
   logic [CFG_W-1:0]   rem_ff;
   logic [CFG_W-1:0]   rem_in;
   logic [CFG_W:0]     rem_sh;
   logic               rem_ge;
   logic [DCNT_W-1:0]  div_cnt_ff;
   logic [DCNT_W-1:0]  div_cnt_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [MEAN_W-1:0]  mean_ff;
   logic               ok_ff;

   // Magnitude of the two's complement sample; the most negative value maps
   // to 2^(SAMPLE_BITS-1), which still fits the unsigned width.
   assign raw = sample;
   assign mag = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;

   // Cells are sorted descending, so the greater-than flags form a run of
   // zeros followed by ones. The first set flag takes the new value and
   // every later one takes its left neighbor.
   always_comb begin
      prev_val[0] = mag;
      for (int i = 0; i < MAX_TOP; i++) begin
         gt[i] = mag > cells_ff[i];
      end
      for (int i = 1; i < MAX_TOP; i++) begin
         prev_val[i] = gt[i-1] ? cells_ff[i-1] : mag;
      end
      for (int i = 0; i < MAX_TOP; i++) begin
         if (cmd.load_out) begin
            cells_in[i] = '0;
         end else if (cmd.insert && gt[i]) begin
            cells_in[i] = prev_val[i];
         end else begin
            cells_in[i] = cells_ff[i];
         end
      end
   end

   always_comb begin
      seen_in = seen_ff;
      if (cmd.load_out) begin
         seen_in = '0;
      end else if (cmd.insert && (seen_ff != COUNT_MAX)) begin
         seen_in = seen_ff + 1'b1;
      end
   end

   // Accumulation lands directly in the dividend register, pre-shifted by the
   // fraction bits, so the divider starts with no separate load step.
   assign rem_sh = {rem_ff, quot_ff[DVD_W-1]};
   assign rem_ge = rem_sh >= {1'b0, maxima_count_ff};

   always_comb begin
      cnt_in     = cnt_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.start) begin
         cnt_in     = '0;
         quot_in    = '0;
         rem_in     = '0;
         div_cnt_in = '0;
      end else if (cmd.sum_step) begin
         cnt_in  = cnt_ff + 1'b1;
         quot_in = quot_ff + (DVD_W'(cells_ff[cnt_ff[IDX_W-1:0]]) << FRAC_BITS);
      end else if (cmd.div_step) begin
         quot_in    = {quot_ff[DVD_W-2:0], rem_ge};
         rem_in     = rem_ge ? CFG_W'(rem_sh - {1'b0, maxima_count_ff}) : rem_sh[CFG_W-1:0];
         div_cnt_in = div_cnt_ff + 1'b1;
      end
   end

   assign rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         maxima_count_ff <= CFG_RESET;
         seen_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < MAX_TOP; i++) begin
            cells_ff[i] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            maxima_count_ff <= csr_write_data;
         end
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < MAX_TOP; i++) begin
            cells_ff[i] <= cells_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      div_cnt_ff <= div_cnt_in;
      if (cmd.load_out) begin
         mean_ff <= stat.k_valid ? MEAN_W'(quot_ff) : '0;
         ok_ff   <= stat.k_valid;
      end
   end

   always_comb begin
      stat.k_valid  = (maxima_count_ff != '0) && (int'(maxima_count_ff) <= MAX_TOP) &&
                      (seen_ff >= maxima_count_ff);
      stat.sum_last = (int'(cnt_ff) + 1) == int'(maxima_count_ff);
      stat.div_done = int'(div_cnt_ff) == (DVD_W - 1);
      stat.out_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mean_scaled = mean_ff;
   assign rsp_ok          = ok_ff;

endmodule

/* tb/mtn_tb_pkg.sv */
// Scoreboard for the top-magnitude mean testbench: a running model of the sorted
// magnitude cells and a queue of expected mean responses. Depends on mtn_pkg.
`timescale 1ns / 1ps
package mtn_tb_pkg;
   import mtn_pkg::*;

   localparam int TB_CELLS       = 16;
   localparam int TB_SAMPLE_BITS = 16;

   typedef struct packed {
      logic [MEAN_W-1:0] mean_scaled;
      logic              ok;
   } mean_result_type;

   class magnitude_mean_tracker;
      logic [TB_SAMPLE_BITS-1:0] top_mags [TB_CELLS];
      logic [COUNT_W-1:0]        series_len;
      logic [CFG_W-1:0]          avg_count;
      mean_result_type           expected_means [$];
      int unsigned               failures;

      function new();
         clear_series();
         avg_count = CFG_RESET;
         failures  = 0;
      endfunction

      function void clear_series();
         int i;
         for (i = 0; i < TB_CELLS; i++) begin
            top_mags[i] = '0;
         end
         series_len = '0;
      endfunction

      function void set_count(logic [CFG_W-1:0] k);
         avg_count = k;
      endfunction

      function int unsigned pending();
         return expected_means.size();
      endfunction

      // Called for every accepted sample transaction.
      function void take_sample(logic signed [TB_SAMPLE_BITS-1:0] value, logic is_last);
         logic [TB_SAMPLE_BITS-1:0] mag;
         logic [31:0]               total;
         mean_result_type           res;
         int                        pos;
         int                        i;
         mag = value;
         if (mag[TB_SAMPLE_BITS-1]) begin
            mag = ~mag + 1'b1;
         end
         pos = TB_CELLS;
         for (i = 0; i < TB_CELLS; i++) begin
            if (pos == TB_CELLS && mag > top_mags[i]) begin
               pos = i;
            end
         end
         for (i = TB_CELLS - 1; i > pos; i--) begin
            top_mags[i] = top_mags[i-1];
         end
         if (pos < TB_CELLS) begin
            top_mags[pos] = mag;
         end
         if (series_len != COUNT_MAX) begin
            series_len++;
         end
         if (!is_last) begin
            return;
         end
         res = '0;
         if (avg_count >= 1 && avg_count <= TB_CELLS && series_len >= avg_count) begin
            total = '0;
            for (i = 0; i < avg_count; i++) begin
               total += top_mags[i];
            end
            res.mean_scaled = MEAN_W'((total << FRAC_BITS) / 32'(avg_count));
            res.ok          = 1'b1;
         end
         expected_means = {expected_means, res};
         clear_series();
      endfunction

      // Called for every accepted mean response transaction.
      function void check_mean(logic [MEAN_W-1:0] mean_scaled, logic ok);
         mean_result_type want;
         if (expected_means.size() == 0) begin
            $error("unexpected response: mean_scaled %0d, ok %0b", mean_scaled, ok);
            failures++;
            return;
         end
         want = expected_means.pop_front();
         if (mean_scaled !== want.mean_scaled) begin
            $error("mean_scaled: expected %0d, actual %0d", want.mean_scaled, mean_scaled);
            failures++;
         end
         if (ok !== want.ok) begin
            $error("ok: expected %0b, actual %0b", want.ok, ok);
            failures++;
         end
      endfunction
   endclass

endpackage

/* tb/mean_of_top_n_abs_values_tb.sv */
// Testbench top for mean_of_top_n_abs_values: drives sample series, writes the
// maxima count between series and checks every mean response against a scoreboard.
// Depends on mtn_pkg, mtn_if, mtn_tb_pkg and the block's RTL.
`timescale 1ns / 1ps
module mean_of_top_n_abs_values_tb;
   import mtn_pkg::*;
   import mtn_tb_pkg::*;

   localparam int SAMPLE_BITS   = TB_SAMPLE_BITS;
   localparam int RANDOM_ITEMS  = 1450;
   // Margin for the slowest response, with K at most TB_CELLS.
   localparam int SETTLE_CYCLES = 80;

   logic clock;
   logic reset;
   logic              csr_write_enable;
   logic [CFG_W-1:0]  csr_write_data;

   mtn_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_ch ();
   mtn_rsp_if                              rsp_ch ();

   mean_of_top_n_abs_values #(
      .MAX_TOP     (TB_CELLS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   magnitude_mean_tracker tracker = new();

   // Idle rates in percent per cycle for the sample sender and the response receiver.
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned items_sent;
   // Maxima count currently held by the block, used to shape series lengths.
   logic [CFG_W-1:0] cur_count;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver decides at each falling edge whether it takes a response in the
   // coming cycle, so stalls land on every phase of the block's work.
   always @(negedge clock) begin
      rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
   end

   // Every response transaction is checked against the oldest expected mean.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         tracker.check_mean(rsp_ch.mean_scaled, rsp_ch.ok);
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      #20_000_000;
      $display("mean_of_top_n_abs_values: mismatch");
      $finish;
   end

   // Sends one sample and waits for its transaction. Entered and left at a falling
   // edge; valid stays high from one sample to the next unless the sender idles.
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value,
                              input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid  = 1'b1;
      req_ch.sample = value;
      req_ch.last   = is_last;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) begin
         @(posedge clock);
      end
      tracker.take_sample(value, is_last);
      items_sent++;
      @(negedge clock);
   endtask

   // Waits until every expected mean has come back, then lets the block finish any
   // work that produces no response before the count register is touched.
   task automatic settle();
      req_ch.valid = 1'b0;
      while (tracker.pending() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_count(input logic [CFG_W-1:0] k);
      csr_write_enable = 1'b1;
      csr_write_data   = k;
      @(negedge clock);
      csr_write_enable = 1'b0;
      tracker.set_count(k);
      cur_count = k;
   endtask

   // Samples lean toward the extremes and toward small values, which produce ties.
   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(9))
         0:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         1:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         2:       return SAMPLE_BITS'($urandom_range(3));
         3:       return -SAMPLE_BITS'($urandom_range(3));
         4:       return SAMPLE_BITS'($urandom_range(1000)) - SAMPLE_BITS'(500);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // Most counts sit inside the cell range; zero and counts past the cells show up too.
   function automatic logic [CFG_W-1:0] pick_count();
      case ($urandom_range(9))
         0, 1:    return CFG_W'(1);
         2, 3:    return CFG_W'(TB_CELLS);
         4:       return '0;
         5:       return CFG_W'($urandom_range(TB_CELLS + 1, 31));
         default: return CFG_W'($urandom_range(2, TB_CELLS - 1));
      endcase
   endfunction

   // Series lengths: mostly ordinary, some too short for the count, some long enough
   // to saturate the sample counter.
   function automatic int unsigned pick_length();
      case ($urandom_range(9))
         0:       return $urandom_range(32, 45);
         1:       return (cur_count > 1) ? $urandom_range(1, cur_count - 1) : 1;
         default: return $urandom_range(1, 20);
      endcase
   endfunction

   task automatic run_series(input int unsigned len);
      int unsigned i;
      for (i = 0; i < len; i++) begin
         send_sample(pick_sample(), i == len - 1);
      end
   endtask

   initial begin
      int          mode;
      int unsigned goal;
      int unsigned series_left;

      clock            = 1'b0;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.sample    = '0;
      req_ch.last      = 1'b0;
      rsp_ch.ready     = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      items_sent       = 0;
      cur_count        = CFG_RESET;

      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Directed part. With a count of one, the most negative sample must keep its
      // full magnitude, which also gives the largest possible mean.
      write_count(CFG_W'(1));
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh0000, 1'b0);
      send_sample(-16'sd1, 1'b1);
      send_sample(16'sh0000, 1'b1);
      send_sample(16'sh8000, 1'b1);
      settle();

      // A series shorter than the count must report not ok with a zero mean, and the
      // next series must start from clear cells.
      write_count(CFG_W'(4));
      send_sample(16'sd5, 1'b0);
      send_sample(-16'sd7, 1'b1);
      send_sample(16'sd1, 1'b0);
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sd100, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b1);
      settle();

      // A count of zero and counts beyond the cells can never be served.
      write_count(CFG_W'(0));
      send_sample(16'sd10, 1'b1);
      settle();
      write_count(CFG_W'(31));
      send_sample(16'sd3, 1'b0);
      send_sample(16'sd4, 1'b1);
      settle();
      write_count(CFG_W'(TB_CELLS + 1));
      send_sample(-16'sd2, 1'b1);

      // Random part in three stretches: a slow receiver, then a slow sender, then
      // both sides at full rate. The count is rewritten every few series, always
      // after the block has drained.
      for (mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 18;
               recv_idle_pct = 68;
            end
            1: begin
               send_idle_pct = 68;
               recv_idle_pct = 18;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         goal        = items_sent + RANDOM_ITEMS / 3;
         series_left = 0;
         while (items_sent < goal) begin
            if (series_left == 0) begin
               settle();
               if (mode == 0 && items_sent < 40) begin
                  write_count(CFG_W'(TB_CELLS));
               end else begin
                  write_count(pick_count());
               end
               series_left = $urandom_range(3, 8);
            end
            run_series(pick_length());
            series_left--;
         end
      end

      settle();
      if (tracker.failures == 0 && tracker.pending() == 0) begin
         $display("mean_of_top_n_abs_values: match");
      end else begin
         $display("mean_of_top_n_abs_values: mismatch");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/mtn_pkg.sv
sv/mtn_if.sv
sv/mtn_ctrl.sv
sv/mtn_datapath.sv
sv/mean_of_top_n_abs_values.sv
tb/mtn_tb_pkg.sv
tb/mean_of_top_n_abs_values_tb.sv
